// ===== hdl/mplf_pkg.sv =====
// Package for the MessagePack object length framer: sizes, codes, types and type-byte table.
package mplf_pkg;

   // Counter widths
   localparam int LENGTH_BITS  = 32;   // byte counter, 16..48
   localparam int PENDING_BITS = 40;   // pending element counter, 34..56
   localparam int HEADER_BITS  = 32;   // collected big-endian length header
   localparam int SKIP_BITS    = 32;   // payload bytes left to skip
   localparam int MSG_LEN_BITS = 32;   // reported length field

   // Type byte boundaries
   localparam logic [7:0] TB_FIXMAP   = 8'h80;
   localparam logic [7:0] TB_FIXARRAY = 8'h90;
   localparam logic [7:0] TB_FIXRAW   = 8'ha0;
   localparam logic [7:0] TB_MID      = 8'hc0;
   localparam logic [7:0] TB_NEGFIX   = 8'he0;

   // Codes for type bytes 0xc0..0xdf
   localparam logic [3:0] CODE_INVALID = 4'd9;   // unknown type byte
   localparam logic [3:0] CODE_RAW16   = 4'd10;  // first of the header-sized types

   // 0-8: payload bytes after the type byte, then raw16, raw32, array16,
   // array32, map16, map32
   localparam logic [3:0] MID_CODES [32] = '{
      4'd0,  4'd9,  4'd0,  4'd0,  4'd9,  4'd9,  4'd9,  4'd9,
      4'd9,  4'd9,  4'd4,  4'd8,  4'd1,  4'd2,  4'd4,  4'd8,
      4'd1,  4'd2,  4'd4,  4'd8,  4'd9,  4'd9,  4'd9,  4'd9,
      4'd9,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

   // Header byte counts
   localparam logic [2:0] HDR_SHORT = 3'd2;
   localparam logic [2:0] HDR_LONG  = 3'd4;

   typedef enum logic [1:0] {
      PH_TYPE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_SKIP   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_ARRAY = 2'd1,
      KIND_MAP   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_TRUNC    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // One input byte as held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } in_item_type;

   // Outcome of one byte step
   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic [MSG_LEN_BITS-1:0] msg_length;
   } step_result_type;

endpackage

// ===== hdl/mplf_req_if.sv =====
// Byte input channel: valid/ready plus one buffer byte.
interface mplf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== hdl/mplf_rsp_if.sv =====
// Result channel: valid/ready plus status and object length.
interface mplf_rsp_if;
   logic                                valid;
   logic                                ready;
   mplf_pkg::status_type                status;
   logic [mplf_pkg::MSG_LEN_BITS-1:0]   msg_length;

   modport source (output valid, output status, output msg_length, input ready);
   modport sink   (input valid, input status, input msg_length, output ready);
endinterface

// ===== hdl/mplf_core.sv =====
// Framer state and the per-byte update: type decode, header collection, payload skip.
module mplf_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  mplf_pkg::in_item_type      item,
   output mplf_pkg::step_result_type  res
);

   localparam int LB = mplf_pkg::LENGTH_BITS;
   localparam int PB = mplf_pkg::PENDING_BITS;
   localparam int HB = mplf_pkg::HEADER_BITS;
   localparam int SB = mplf_pkg::SKIP_BITS;
   localparam logic [LB-1:0] LEN_MAX = '1;

   mplf_pkg::phase_type  phase_ff, phase_in;
   mplf_pkg::kind_type   kind_ff, kind_in;
   logic [2:0]           header_left_ff, header_left_in;
   logic [HB-1:0]        header_value_ff, header_value_in;
   logic [SB-1:0]        skip_left_ff, skip_left_in;
   logic [PB-1:0]        pending_ff, pending_in;
   logic [LB-1:0]        byte_count_ff, byte_count_in;

   logic                 emit;
   mplf_pkg::status_type emit_status;
   logic [HB-1:0]        hv_shift;
   logic [PB-1:0]        pend_dec;
   logic                 add_en;
   logic [PB-1:0]        add_base;
   logic [PB-1:0]        add_val;
   logic [PB:0]          add_sum;
   logic [3:0]           mid_code;
   logic [2:0]           hdr_sel;
   logic [7:0]           b;

   assign b        = item.data_byte;
   assign hv_shift = {header_value_ff[HB-9:0], b};
   assign pend_dec = pending_ff - PB'(pending_ff != '0);
   assign mid_code = mplf_pkg::MID_CODES[b[4:0]];
   assign hdr_sel  = 3'(mid_code - mplf_pkg::CODE_RAW16);

   // Next state for one byte
   always_comb begin
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      header_left_in  = header_left_ff;
      header_value_in = header_value_ff;
      skip_left_in    = skip_left_ff;
      pending_in      = pending_ff;
      byte_count_in   = byte_count_ff;
      emit            = 1'b0;
      emit_status     = mplf_pkg::ST_OK;
      add_en          = 1'b0;
      add_base        = pending_ff;
      add_val         = '0;
      add_sum         = '0;

      if (byte_count_ff == LEN_MAX) begin
         // byte counter full wins over everything else
         emit        = 1'b1;
         emit_status = mplf_pkg::ST_OVERFLOW;
      end else begin
         byte_count_in = byte_count_ff + LB'(1);
         unique case (phase_ff)
            mplf_pkg::PH_TYPE: begin
               pending_in = pend_dec;
               add_base   = pend_dec;
               if (b < mplf_pkg::TB_FIXMAP || b >= mplf_pkg::TB_NEGFIX) begin
                  // fixnum: nothing follows
               end else if (b < mplf_pkg::TB_FIXARRAY) begin
                  add_en  = 1'b1;
                  add_val = PB'({b[3:0], 1'b0});
               end else if (b < mplf_pkg::TB_FIXRAW) begin
                  add_en  = 1'b1;
                  add_val = PB'(b[3:0]);
               end else if (b < mplf_pkg::TB_MID) begin
                  skip_left_in = SB'(b[4:0]);
               end else if (mid_code == mplf_pkg::CODE_INVALID) begin
                  emit        = 1'b1;
                  emit_status = mplf_pkg::ST_INVALID;
               end else if (mid_code < mplf_pkg::CODE_INVALID) begin
                  skip_left_in = SB'(mid_code);
               end else begin
                  header_left_in  = hdr_sel[0] ? mplf_pkg::HDR_LONG : mplf_pkg::HDR_SHORT;
                  kind_in         = mplf_pkg::kind_type'(hdr_sel[2:1]);
                  header_value_in = '0;
                  phase_in        = mplf_pkg::PH_HEADER;
               end
               if (phase_in == mplf_pkg::PH_TYPE && skip_left_in != '0)
                  phase_in = mplf_pkg::PH_SKIP;
            end
            mplf_pkg::PH_HEADER: begin
               header_value_in = hv_shift;
               header_left_in  = header_left_ff - 3'(header_left_ff != '0);
               if (header_left_in == '0) begin
                  if (kind_ff == mplf_pkg::KIND_RAW) begin
                     skip_left_in = SB'(hv_shift);
                  end else begin
                     add_en  = 1'b1;
                     add_val = (kind_ff == mplf_pkg::KIND_MAP) ? PB'({hv_shift, 1'b0})
                                                             : PB'(hv_shift);
                  end
                  header_value_in = '0;
                  kind_in         = mplf_pkg::KIND_RAW;
                  phase_in        = (skip_left_in != '0) ? mplf_pkg::PH_SKIP
                                                         : mplf_pkg::PH_TYPE;
               end
            end
            mplf_pkg::PH_SKIP: begin
               skip_left_in = skip_left_ff - SB'(skip_left_ff != '0);
               if (skip_left_in == '0)
                  phase_in = mplf_pkg::PH_TYPE;
            end
            default: begin
               phase_in = mplf_pkg::PH_TYPE;
            end
         endcase

         // element count add, flagged on carry out
         if (add_en) begin
            add_sum = {1'b0, add_base} + {1'b0, add_val};
            if (add_sum[PB]) begin
               emit        = 1'b1;
               emit_status = mplf_pkg::ST_OVERFLOW;
            end else begin
               pending_in = add_sum[PB-1:0];
            end
         end

         // completion or early end of buffer
         if (!emit) begin
            if (phase_in == mplf_pkg::PH_TYPE && pending_in == '0) begin
               emit        = 1'b1;
               emit_status = mplf_pkg::ST_OK;
            end else if (item.end_of_buffer) begin
               emit        = 1'b1;
               emit_status = mplf_pkg::ST_TRUNC;
            end
         end
      end
   end

   // Result the held byte would give; it counts only when step_en is high
   always_comb begin
      res.valid      = emit;
      res.status     = emit_status;
      res.msg_length = (emit_status == mplf_pkg::ST_OK)
                       ? mplf_pkg::MSG_LEN_BITS'(byte_count_in) : '0;
   end

   // State registers; any result restarts the scan
   always_ff @(posedge clock) begin
      if (reset || (step_en && emit)) begin
         phase_ff        <= mplf_pkg::PH_TYPE;
         kind_ff         <= mplf_pkg::KIND_RAW;
         header_left_ff  <= '0;
         header_value_ff <= '0;
         skip_left_ff    <= '0;
         pending_ff      <= PB'(1);
         byte_count_ff   <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         header_left_ff  <= header_left_in;
         header_value_ff <= header_value_in;
         skip_left_ff    <= skip_left_in;
         pending_ff      <= pending_in;
         byte_count_ff   <= byte_count_in;
      end
   end

   // After a result the next byte starts a fresh object
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && res.valid |=> phase_ff == mplf_pkg::PH_TYPE && pending_ff == PB'(1)
                    && byte_count_ff == '0)
      else $error("state not restarted after result");

   // Waiting on a type byte always means something is still pending
   a_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mplf_pkg::PH_TYPE |-> pending_ff != '0)
      else $error("type phase with no pending element");

   // Header and skip phases always have work left
   a_work_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mplf_pkg::PH_HEADER
         || (header_left_ff != '0 && header_left_ff <= mplf_pkg::HDR_LONG))
      && (phase_ff != mplf_pkg::PH_SKIP || skip_left_ff != '0))
      else $error("header or skip phase with nothing left");

endmodule

// ===== hdl/msgpack_message_length_framer_unit.sv =====
// Top level of the MessagePack object length framer: input register, step core, result register.
//
//  channel | dir | handshake    | payload
//  req_*   | in  | valid/ready  | data_byte[7:0], end_of_buffer
//  rsp_*   | out | valid/ready  | status[1:0], msg_length[31:0]
//
// One byte per clock sustained, except while a held result stalls a step that produces a result.
// A byte is registered in the input register at its transfer, stepped through mplf_core,
// and its result (if any) is registered in the result register when that step fires.
// Reset is synchronous and clears both registers and the scan state.
// A held result stalls the step only when that step produces another result;
// bytes that finish no object keep flowing while rsp is stalled.
module msgpack_message_length_framer_unit (
   input logic        clock,
   input logic        reset,
   mplf_req_if.sink   req_port,
   mplf_rsp_if.source rsp_port
);

   logic                      in_valid_ff;
   mplf_pkg::in_item_type     in_item_ff;
   logic                      out_valid_ff;
   mplf_pkg::status_type      out_status_ff;
   logic [mplf_pkg::MSG_LEN_BITS-1:0] out_length_ff;
   logic                      out_free;
   logic                      step_fire;
   mplf_pkg::step_result_type res;

   // Step when a byte is held and a result, if any, has room
   assign out_free  = !out_valid_ff || rsp_port.ready;
   assign step_fire = in_valid_ff && (out_free || !res.valid);
   assign req_port.ready = !in_valid_ff || step_fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.valid && req_port.ready) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_item_ff.data_byte     <= req_port.data_byte;
         in_item_ff.end_of_buffer <= req_port.end_of_buffer;
      end
   end

   mplf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .item    (in_item_ff),
      .res     (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res.valid && step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && step_fire) begin
         out_status_ff <= res.status;
         out_length_ff <= res.msg_length;
      end
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.status     = out_status_ff;
   assign rsp_port.msg_length = out_length_ff;

   // A stepped result always lands in the result register
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      res.valid && step_fire |=> out_valid_ff)
      else $error("result dropped");

   // Error results carry no length
   a_err_len: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != mplf_pkg::ST_OK |-> out_length_ff == '0)
      else $error("length on error result");

   // A held byte that was not stepped stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_fire |=> in_valid_ff && $stable(in_item_ff))
      else $error("input byte lost while stalled");

endmodule
